[design/brlt_pkg.sv]
// shared types and codes for the byte range lock table
package brlt_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = 4;
    localparam int FILE_W = 10;
    localparam int OFF_W = 48;
    localparam int CNT_W = 32;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [1:0] REPLY_ACQUIRE = 2'd0;
    localparam logic [1:0] REPLY_GRANT = 2'd1;
    localparam logic [1:0] REPLY_ACK = 2'd2;

    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_FULL = 2'd1;
    localparam logic [1:0] ERR_NOT_HELD = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [FILE_W-1:0] file_id;
        logic [OFF_W-1:0]  start_offset;
        logic [CNT_W-1:0]  byte_count;
        logic              write_mode;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [1:0]        reply_kind;
        logic [SLOT_W-1:0] slot_id;
        logic              is_granted;
        logic [1:0]        error_code;
        logic              last_of_run;
    } rsp_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              acq_en;
        logic              rel_en;
        logic [SLOTS-1:0]  rel_bit;
        logic [FILE_W-1:0] file_id;
        logic [OFF_W-1:0]  start_offset;
        logic [OFF_W-1:0]  end_offset;
        logic              write_mode;
    } cell_cmd_t;

endpackage

[design/brlt_cell.sv]
// one lock slot: range, mode, blocker mask, pending grant and scan token
module brlt_cell
    import brlt_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_cmd_t        cmd,
    input  logic [SLOTS-1:0] blk_in,
    input  logic             free_in,
    output logic             free_out,
    input  logic             tok_in,
    output logic             tok_out,
    output logic             valid,
    output logic             hit,
    output logic             emit
);

    logic              valid_reg, valid_next;
    logic [SLOTS-1:0]  blk_reg, blk_next;
    logic              pend_reg, pend_next;
    logic              tok_reg;
    logic [FILE_W-1:0] file_reg;
    logic [OFF_W-1:0]  start_reg;
    logic [OFF_W-1:0]  end_reg;
    logic              write_reg;
    logic              claim;
    logic [SLOTS-1:0]  blk_left;

    assign claim = cmd.acq_en && !valid_reg && !free_in;
    assign free_out = free_in || !valid_reg;
    assign hit = valid_reg && (file_reg == cmd.file_id) && (cmd.write_mode || write_reg)
                 && (start_reg <= cmd.end_offset) && (cmd.start_offset <= end_reg);
    assign valid = valid_reg;
    assign tok_out = tok_reg;
    assign emit = tok_reg && pend_reg;
    assign blk_left = blk_reg & ~cmd.rel_bit;

    always_comb
    begin
        valid_next = valid_reg;
        blk_next = blk_reg;
        pend_next = pend_reg && !tok_reg;
        if (claim)
        begin
            valid_next = 1'b1;
            blk_next = blk_in;
        end
        else if (cmd.rel_en)
        begin
            if (cmd.rel_bit[IDX])
            begin
                valid_next = 1'b0;
                blk_next = '0;
            end
            else if (valid_reg && ((blk_reg & cmd.rel_bit) != '0))
            begin
                blk_next = blk_left;
                // last blocker gone: grant waits for the scan token
                if (blk_left == '0)
                begin
                    pend_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            blk_reg <= '0;
            pend_reg <= 1'b0;
            tok_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            blk_reg <= blk_next;
            pend_reg <= pend_next;
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            file_reg <= cmd.file_id;
            start_reg <= cmd.start_offset;
            end_reg <= cmd.end_offset;
            write_reg <= cmd.write_mode;
        end
    end

endmodule

[design/byte_range_lock_table.sv]
// Byte range lock table, top level. A request is taken when start is high and
// busy is low; each reply shows on rsp for one cycle with rsp_valid high and
// cannot be held off. An acquire, a release of an unheld slot, and a full
// table each give one reply. A release of a held slot sends a scan token
// down the row of SLOTS cells, one cell per cycle, emitting a grant as it
// passes each newly unblocked slot, then an acknowledge. The overlap check
// against every held slot runs in parallel in the cells.
module byte_range_lock_table
    import brlt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic rsp_valid,
    output rsp_t rsp
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_ACK} state_t;

    state_t            state_reg;
    req_t              req_reg;
    logic [OFF_W-1:0]  end_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    cell_cmd_t         cmd;
    logic [SLOTS-1:0]  valid_vec, hit_vec, emit_vec, tok_vec;
    logic [SLOTS:0]    free_chain;
    logic [SLOTS:0]    tok_chain;
    logic [SLOTS-1:0]  slot_bit;
    logic              held;
    logic              full;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] emit_idx;
    logic [CNT_W-1:0]  cnt_m1;
    logic [OFF_W:0]    end_sum;

    assign cnt_m1 = (req.byte_count == '0) ? '0 : req.byte_count - CNT_W'(1);
    assign end_sum = {1'b0, req.start_offset} + {{(OFF_W + 1 - CNT_W){1'b0}}, cnt_m1};

    assign slot_bit = SLOTS'(1) << req_reg.slot;
    assign held = (valid_vec & slot_bit) != '0;
    assign full = !free_chain[SLOTS];

    assign cmd.acq_en = (state_reg == S_EXEC) && (req_reg.kind == KIND_ACQUIRE);
    assign cmd.rel_en = (state_reg == S_EXEC) && (req_reg.kind == KIND_RELEASE) && held;
    assign cmd.rel_bit = slot_bit;
    assign cmd.file_id = req_reg.file_id;
    assign cmd.start_offset = req_reg.start_offset;
    assign cmd.end_offset = end_reg;
    assign cmd.write_mode = req_reg.write_mode;

    assign free_chain[0] = 1'b0;
    assign tok_chain[0] = cmd.rel_en;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        brlt_cell #(.IDX(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .blk_in   (hit_vec),
            .free_in  (free_chain[i]),
            .free_out (free_chain[i+1]),
            .tok_in   (tok_chain[i]),
            .tok_out  (tok_vec[i]),
            .valid    (valid_vec[i]),
            .hit      (hit_vec[i]),
            .emit     (emit_vec[i])
        );
        assign tok_chain[i+1] = tok_vec[i];
    end

    always_comb
    begin
        free_idx = '0;
        emit_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (free_chain[i+1] && !free_chain[i])
            begin
                free_idx = free_idx | SLOT_W'(i);
            end
            if (emit_vec[i])
            begin
                emit_idx = emit_idx | SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    rsp_valid_reg <= 1'b1;
                    state_reg <= cmd.rel_en ? S_SCAN : S_IDLE;
                    if (req_reg.kind == KIND_ACQUIRE)
                    begin
                        rsp_reg.reply_kind <= REPLY_ACQUIRE;
                        rsp_reg.slot_id <= full ? '0 : free_idx;
                        rsp_reg.is_granted <= !full && (hit_vec == '0);
                        rsp_reg.error_code <= full ? ERR_FULL : ERR_OK;
                        rsp_reg.last_of_run <= 1'b1;
                    end
                    else
                    begin
                        // held release replies only after the scan
                        rsp_valid_reg <= !held;
                        rsp_reg.reply_kind <= REPLY_ACK;
                        rsp_reg.slot_id <= req_reg.slot;
                        rsp_reg.is_granted <= 1'b0;
                        rsp_reg.error_code <= ERR_NOT_HELD;
                        rsp_reg.last_of_run <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (emit_vec != '0)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg.reply_kind <= REPLY_GRANT;
                        rsp_reg.slot_id <= emit_idx;
                        rsp_reg.is_granted <= 1'b1;
                        rsp_reg.error_code <= ERR_OK;
                        rsp_reg.last_of_run <= 1'b0;
                    end
                    if (tok_vec[SLOTS-1])
                    begin
                        state_reg <= S_ACK;
                    end
                end
                S_ACK:
                begin
                    rsp_valid_reg <= 1'b1;
                    rsp_reg.reply_kind <= REPLY_ACK;
                    rsp_reg.slot_id <= req_reg.slot;
                    rsp_reg.is_granted <= 1'b0;
                    rsp_reg.error_code <= ERR_OK;
                    rsp_reg.last_of_run <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == S_IDLE)
        begin
            req_reg <= req;
            end_reg <= end_sum[OFF_W] ? {OFF_W{1'b1}} : end_sum[OFF_W-1:0];
        end
    end

    assign busy = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

[design/brlt_checker.sv]
// port-level checks for the byte range lock table
module brlt_port_checks
    import brlt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic rsp_valid,
    input rsp_t rsp
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    a_reply_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $past(busy))
        else $error("reply without a request in progress");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last_of_run |=> !rsp_valid)
        else $error("reply right after final reply");

    a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.error_code == ERR_FULL || rsp.error_code == ERR_NOT_HELD)
        |-> rsp.last_of_run && !rsp.is_granted)
        else $error("error reply not final or granted");

endmodule

bind byte_range_lock_table brlt_port_checks u_brlt_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
);
